>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the timer table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checks that a property holds at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that a condition never holds at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

>>> src/ptt_pkg.sv
// ----------------------------------------------------------------------------
// Periodic timer table package
// Sizes, codes and shared types of the timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

    // Number of timer slots.
    localparam int TIMERS = 16;
    // Slot index width and entry count width.
    localparam int IDX_W  = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CNT_W  = $clog2(TIMERS + 1);

    // Operation codes carried on the input tuser.
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ADD  = 2'd1,
        OP_DEL  = 2'd2
    } op_t;

    // Result kinds carried on the output tuser.
    typedef enum logic [2:0] {
        KIND_FIRED     = 3'd0,
        KIND_ADDED     = 3'd1,
        KIND_FULL      = 3'd2,
        KIND_DELETED   = 3'd3,
        KIND_NOT_FOUND = 3'd4,
        KIND_TICK_DONE = 3'd5
    } kind_t;

    // One stored timer entry.
    typedef struct packed {
        logic [31:0] last_time;
        logic [7:0]  hook;
        logic [15:0] period;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Access request from the sequencer to the entry memory.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

endpackage

>>> src/ptt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/ptt_engine.sv
// ----------------------------------------------------------------------------
// Timer table sequencer
// Walks the entry memory for ticks and deletes, writes new entries for adds,
// and drives the result output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptt_engine
    import ptt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [55:0] s_tdata,   // period_seconds [15:0], hook_id [23:16], now_seconds [55:24]
    input  logic [1:0] s_tuser,    // operation [1:0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // fired_hook [7:0]
    output logic [2:0] m_tuser,    // result_kind [2:0]
    output logic       m_tlast,
    output mem_req_t   mem_req,
    input  entry_t     rd_entry
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_TICK  = 5'b00010,
        S_DEL   = 5'b00100,
        S_SHIFT = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      now_reg, now_next;
    logic [15:0]      period_reg, period_next;
    logic [7:0]       hook_reg, hook_next;
    kind_t            kind_reg, kind_next;
    logic             out_valid_reg, out_valid_next;
    kind_t            out_kind_reg, out_kind_next;
    logic [7:0]       out_hook_reg, out_hook_next;
    logic             out_last_reg, out_last_next;

    logic             out_free;
    logic             accept;
    logic             out_load;
    kind_t            load_kind;
    logic [7:0]       load_hook;
    logic             load_last;
    logic [CNT_W-1:0] count_m1;
    logic [IDX_W-1:0] last_idx;
    logic [31:0]      elapsed;
    logic             fire;
    logic             match;
    logic             table_full;

    // Handshake and helper terms.
    assign out_free   = !out_valid_reg || m_tready;
    assign s_tready   = (state_reg == S_IDLE) && out_free;
    assign accept     = s_tvalid && s_tready;
    assign count_m1   = count_reg - CNT_W'(1);
    assign last_idx   = count_m1[IDX_W-1:0];
    assign elapsed    = now_reg - rd_entry.last_time;
    assign fire       = elapsed >= {16'd0, rd_entry.period};
    assign match      = (rd_entry.period == period_reg) && (rd_entry.hook == hook_reg);
    assign table_full = (count_reg == CNT_W'(TIMERS));

    // Sequencer: at most one memory read and at most one write per cycle.
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        now_next    = now_reg;
        period_next = period_reg;
        hook_next   = hook_reg;
        kind_next   = kind_reg;
        mem_req     = '0;
        out_load    = 1'b0;
        load_kind   = KIND_TICK_DONE;
        load_hook   = 8'd0;
        load_last   = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    now_next    = s_tdata[55:24];
                    period_next = s_tdata[15:0];
                    hook_next   = s_tdata[23:16];
                    case (s_tuser)
                        OP_TICK:
                        begin
                            if (count_reg == '0)
                            begin
                                out_load  = 1'b1;
                                load_kind = KIND_TICK_DONE;
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = last_idx;
                                idx_next      = last_idx;
                                state_next    = S_TICK;
                            end
                        end
                        OP_ADD:
                        begin
                            out_load = 1'b1;
                            if (table_full)
                            begin
                                load_kind = KIND_FULL;
                            end
                            else
                            begin
                                load_kind                = KIND_ADDED;
                                mem_req.we               = 1'b1;
                                mem_req.waddr            = count_reg[IDX_W-1:0];
                                mem_req.wdata.last_time  = s_tdata[55:24];
                                mem_req.wdata.hook       = s_tdata[23:16];
                                mem_req.wdata.period     = s_tdata[15:0];
                                count_next               = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DEL:
                        begin
                            if (count_reg == '0)
                            begin
                                out_load  = 1'b1;
                                load_kind = KIND_NOT_FOUND;
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = last_idx;
                                idx_next      = last_idx;
                                state_next    = S_DEL;
                            end
                        end
                        default:
                        begin
                            // Unused operation code: no effect and no result.
                        end
                    endcase
                end
            end

            S_TICK:
            begin
                // A firing entry waits here until the output register is free.
                if (!fire || out_free)
                begin
                    if (fire)
                    begin
                        mem_req.we              = 1'b1;
                        mem_req.waddr           = idx_reg;
                        mem_req.wdata.last_time = now_reg;
                        mem_req.wdata.hook      = rd_entry.hook;
                        mem_req.wdata.period    = rd_entry.period;
                        out_load                = 1'b1;
                        load_kind               = KIND_FIRED;
                        load_hook               = rd_entry.hook;
                        load_last               = 1'b0;
                    end
                    if (idx_reg == '0)
                    begin
                        kind_next  = KIND_TICK_DONE;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = idx_reg - IDX_W'(1);
                        idx_next      = idx_reg - IDX_W'(1);
                    end
                end
            end

            S_DEL:
            begin
                if (match)
                begin
                    if (idx_reg == last_idx)
                    begin
                        count_next = count_m1;
                        kind_next  = KIND_DELETED;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = idx_reg + IDX_W'(1);
                        idx_next      = idx_reg + IDX_W'(1);
                        state_next    = S_SHIFT;
                    end
                end
                else if (idx_reg == '0)
                begin
                    kind_next  = KIND_NOT_FOUND;
                    state_next = S_EMIT;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = idx_reg - IDX_W'(1);
                    idx_next      = idx_reg - IDX_W'(1);
                end
            end

            S_SHIFT:
            begin
                // Move the entry just read one slot down to close the gap.
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg - IDX_W'(1);
                mem_req.wdata = rd_entry;
                if (idx_reg == last_idx)
                begin
                    count_next = count_m1;
                    kind_next  = KIND_DELETED;
                    state_next = S_EMIT;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = idx_reg + IDX_W'(1);
                    idx_next      = idx_reg + IDX_W'(1);
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_kind  = kind_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register next values.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_hook_next  = out_hook_reg;
        out_last_next  = out_last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = load_kind;
            out_hook_next  = load_hook;
            out_last_next  = load_last;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        now_reg      <= now_next;
        period_reg   <= period_next;
        hook_reg     <= hook_next;
        kind_reg     <= kind_next;
        out_kind_reg <= out_kind_next;
        out_hook_reg <= out_hook_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_hook_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // Checks on the sequencer.
    `ASSERT_NEVER(a_count_range, clk, rst_n, count_reg > CNT_W'(TIMERS), "entry count above table size")
    `ASSERT_NEVER(a_no_overwrite, clk, rst_n, out_load && out_valid_reg && !m_tready, "result overwritten while stalled")
    `ASSERT_NEVER(a_rw_same_slot, clk, rst_n, mem_req.we && mem_req.re && (mem_req.waddr == mem_req.raddr), "read and write of one slot in one cycle")
    `ASSERT_PROP(a_full_keeps_count, clk, rst_n, (accept && (s_tuser == OP_ADD) && table_full) |=> $stable(count_reg), "add to full table changed the count")

endmodule

>>> src/periodic_timer_table_unit.sv
// Latency: add, and tick or delete on an empty table, give their word the cycle after acceptance.
// A tick reads one entry per cycle from the single memory read port unless a firing entry stalls.
// A delete scans down to the match and then moves each newer entry one slot per cycle.
// One item is worked at a time; a new item is taken after the last result, when the output is free.
// Reset clears the state, entry count and output valid; the memory is not cleared and needs no pass.
// ----------------------------------------------------------------------------
// Periodic timer table unit
// Table of periodic timers with add, delete and tick operations.
// ----------------------------------------------------------------------------
module periodic_timer_table_unit
    import ptt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // period_seconds [15:0], hook_id [23:16], now_seconds [55:24]
    input  logic [1:0]  s_tuser,   // operation [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // fired_hook [7:0]
    output logic [2:0]  m_tuser,   // result_kind [2:0]
    output logic        m_tlast
);

    mem_req_t             mem_req;
    entry_t               rd_entry;
    logic [ENTRY_W-1:0]   rd_bits;

    // Entry memory: period, hook and last firing or add time per slot.
    ptt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TIMERS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rd_bits)
    );

    assign rd_entry = entry_t'(rd_bits);

    // Sequencer and result register.
    ptt_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .mem_req  (mem_req),
        .rd_entry (rd_entry)
    );

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// Periodic timer table testbench
// Drives tick, add and delete commands into the timer table in random
// bursts, predicts every result word from a shadow copy of the table, and
// checks the returned words in order while the receiver stalls at random.
// ----------------------------------------------------------------------------
module testbench
    import ptt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The one operation code that the block ignores.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_CMDS = 400;
    localparam int DRAIN_CYCLES = 50;

    // One command as it travels on the input side.
    typedef struct {
        logic [1:0]  op;
        logic [15:0] period;
        logic [7:0]  hook;
        logic [31:0] now_s;
    } timer_cmd_t;

    // One result word as it travels on the output side.
    typedef struct {
        kind_t      kind;
        logic [7:0] hook;
        logic       last;
    } timer_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;   // period_seconds [15:0], hook_id [23:16], now_seconds [55:24]
    logic [1:0]  s_tuser = '0;   // operation [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // fired_hook [7:0]
    logic [2:0]  m_tuser;        // result_kind [2:0]
    logic        m_tlast;

    timer_cmd_t  cmd_queue[$];
    timer_word_t predicted_words[$];

    // Shadow copy of the timer table.
    logic [15:0] tmr_period [TIMERS];
    logic [7:0]  tmr_hook   [TIMERS];
    logic [31:0] tmr_last   [TIMERS];
    int          tmr_count = 0;

    // Run statistics and the failure count.
    int error_count = 0;
    int n_ticks = 0, n_adds = 0, n_dels = 0, n_ignored = 0;
    int n_fired = 0, n_full = 0, n_del_hit = 0, n_del_miss = 0, peak_count = 0;

    periodic_timer_table_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reset held low at the start of the run, then released.
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic void queue_word(kind_t kind, logic [7:0] hook, logic last);
        timer_word_t w;
        w.kind = kind;
        w.hook = hook;
        w.last = last;
        predicted_words.push_back(w);
    endfunction

    // Updates the shadow table for one accepted command and queues its words.
    function automatic void apply_timer_cmd(logic [1:0] op, logic [15:0] period,
                                            logic [7:0] hook, logic [31:0] now_s);
        logic [31:0] elapsed;
        int          hit;
        hit = -1;
        case (op)
            OP_TICK:
            begin
                n_ticks++;
                // Newest entry first; a wrapping difference decides the firing.
                for (int i = tmr_count - 1; i >= 0; i--)
                begin
                    elapsed = now_s - tmr_last[i];
                    if (elapsed >= {16'd0, tmr_period[i]})
                    begin
                        queue_word(KIND_FIRED, tmr_hook[i], 1'b0);
                        tmr_last[i] = now_s;
                        n_fired++;
                    end
                end
                queue_word(KIND_TICK_DONE, 8'd0, 1'b1);
            end
            OP_ADD:
            begin
                n_adds++;
                if (tmr_count >= TIMERS)
                begin
                    queue_word(KIND_FULL, 8'd0, 1'b1);
                    n_full++;
                end
                else
                begin
                    tmr_period[tmr_count] = period;
                    tmr_hook[tmr_count]   = hook;
                    tmr_last[tmr_count]   = now_s;
                    tmr_count++;
                    if (tmr_count > peak_count)
                        peak_count = tmr_count;
                    queue_word(KIND_ADDED, 8'd0, 1'b1);
                end
            end
            OP_DEL:
            begin
                n_dels++;
                // The newest matching entry goes; newer ones close the gap.
                for (int i = tmr_count - 1; i >= 0 && hit < 0; i--)
                    if (tmr_period[i] == period && tmr_hook[i] == hook)
                        hit = i;
                if (hit >= 0)
                begin
                    for (int j = hit; j < tmr_count - 1; j++)
                    begin
                        tmr_period[j] = tmr_period[j + 1];
                        tmr_hook[j]   = tmr_hook[j + 1];
                        tmr_last[j]   = tmr_last[j + 1];
                    end
                    tmr_count--;
                    queue_word(KIND_DELETED, 8'd0, 1'b1);
                    n_del_hit++;
                end
                else
                begin
                    queue_word(KIND_NOT_FOUND, 8'd0, 1'b1);
                    n_del_miss++;
                end
            end
            default:
                n_ignored++;
        endcase
    endfunction

    function automatic void push_cmd(logic [1:0] op, logic [15:0] period,
                                     logic [7:0] hook, logic [31:0] now_s);
        timer_cmd_t c;
        c.op     = op;
        c.period = period;
        c.hook   = hook;
        c.now_s  = now_s;
        cmd_queue.push_back(c);
    endfunction

    // Mostly short periods so that timers fire, now and then any value.
    function automatic logic [15:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 16'($urandom_range(0, 8));
        else if (r < 90)
            return 16'($urandom_range(9, 64));
        return 16'($urandom_range(0, 65535));
    endfunction

    // A small pool of hooks makes duplicates common.
    function automatic logic [7:0] pick_hook();
        if ($urandom_range(0, 9) < 7)
            return 8'($urandom_range(0, 15));
        return 8'($urandom_range(0, 255));
    endfunction

    // Driver: sends words in bursts of random length with random gaps.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        timer_cmd_t next_cmd;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                apply_timer_cmd(s_tuser, s_tdata[15:0], s_tdata[23:16], s_tdata[55:24]);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0 || cmd_queue.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    next_cmd = cmd_queue.pop_front();
                    s_tdata  <= {next_cmd.now_s, next_cmd.hook, next_cmd.period};
                    s_tuser  <= next_cmd.op;
                    s_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 30);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            1:       gap_left = $urandom_range(15, 25);
                            default: gap_left = $urandom_range(1, 6);
                        endcase
                    end
                end
            end
        end
    end

    // Monitor: checks each returned word and stalls on windows of its own.
    int stall_mode = 0;
    int stall_window = 0;

    always @(posedge clk or negedge rst_n)
    begin
        timer_word_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_words.size() == 0)
                begin
                    $error("unexpected word: result_kind %0d fired_hook 0x%0h last_of_run %0b",
                           m_tuser, m_tdata, m_tlast);
                    error_count++;
                end
                else
                begin
                    want = predicted_words.pop_front();
                    if (m_tuser !== want.kind)
                    begin
                        $error("result_kind: expected %0d, actual %0d", want.kind, m_tuser);
                        error_count++;
                    end
                    if (m_tdata !== want.hook)
                    begin
                        $error("fired_hook: expected 0x%0h, actual 0x%0h", want.hook, m_tdata);
                        error_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_of_run: expected %0b, actual %0b", want.last, m_tlast);
                        error_count++;
                    end
                end
            end
            // Switch between always ready, coin toss and rare ready.
            if (stall_window == 0)
            begin
                stall_mode   = $urandom_range(0, 2);
                stall_window = $urandom_range(20, 80);
            end
            else
                stall_window--;
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Stimulus, then the drain and the verdict.
    initial
    begin : stimulus
        int          counted;
        int          block_left;
        int          r;
        int          tick_w, add_w, del_w;
        logic [31:0] clk_s;
        logic [23:0] pair;
        logic [23:0] added_pairs[$];

        // Empty table: a tick gives only its done word, a delete misses.
        push_cmd(OP_TICK, 16'd0, 8'd0, 32'd0);
        push_cmd(OP_DEL, 16'h1234, 8'h56, 32'd0);
        // Zero period, widest period and hook, and an ordinary timer.
        push_cmd(OP_ADD, 16'd0, 8'h00, 32'd0);
        push_cmd(OP_ADD, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        push_cmd(OP_ADD, 16'd5, 8'hA5, 32'd100);
        // The unused code is ignored.
        push_cmd(OP_UNUSED, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        // A tick at the top of time, then one second back so the difference wraps.
        push_cmd(OP_TICK, 16'd0, 8'd0, 32'hFFFF_FFFF);
        push_cmd(OP_TICK, 16'd0, 8'd0, 32'hFFFF_FFFE);
        // Delete the oldest entry, then miss on the hook alone.
        push_cmd(OP_DEL, 16'd0, 8'h00, 32'd0);
        push_cmd(OP_DEL, 16'd5, 8'hA6, 32'd0);
        // Fill the table with look-alike entries and add once more when full.
        for (int i = 0; i < 15; i++)
            push_cmd(OP_ADD, (i % 2) ? 16'd3 : 16'd2, 8'h3C, 32'd200 + i);
        // A tick over a full table, then remove the newest duplicate.
        push_cmd(OP_TICK, 16'd0, 8'd0, 32'd205);
        push_cmd(OP_DEL, 16'd3, 8'h3C, 32'd0);

        // Random part in blocks that lean toward ticks, adds or deletes.
        counted    = 0;
        block_left = 0;
        clk_s      = 32'd300;
        tick_w     = 0;
        add_w      = 0;
        del_w      = 0;
        while (counted < RANDOM_CMDS)
        begin
            if (block_left == 0)
            begin
                block_left = $urandom_range(15, 40);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        tick_w = 40; add_w = 30; del_w = 26;
                    end
                    1:
                    begin
                        tick_w = 25; add_w = 55; del_w = 17;
                    end
                    default:
                    begin
                        tick_w = 35; add_w = 20; del_w = 42;
                    end
                endcase
            end
            block_left--;
            // Time mostly creeps forward, sometimes jumps, steps back or lands anywhere.
            r = $urandom_range(0, 99);
            if (r < 80)
                clk_s += $urandom_range(0, 3);
            else if (r < 93)
                clk_s += $urandom_range(4, 200);
            else if (r < 97)
                clk_s -= $urandom_range(1, 20);
            else
                clk_s = $urandom;
            r = $urandom_range(0, 99);
            if (r >= tick_w + add_w + del_w)
                push_cmd(OP_UNUSED, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                         $urandom);
            else
            begin
                counted++;
                if (r < tick_w)
                    push_cmd(OP_TICK, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                             clk_s);
                else if (r < tick_w + add_w)
                begin
                    pair = {pick_hook(), pick_period()};
                    push_cmd(OP_ADD, pair[15:0], pair[23:16], clk_s);
                    added_pairs.push_back(pair);
                    if (added_pairs.size() > 24)
                        void'(added_pairs.pop_front());
                end
                else
                begin
                    // Most deletes name a timer added earlier; the rest are guesses.
                    if (added_pairs.size() > 0 && $urandom_range(0, 4) != 0)
                        pair = added_pairs[$urandom_range(0, added_pairs.size() - 1)];
                    else
                        pair = {pick_hook(), pick_period()};
                    push_cmd(OP_DEL, pair[15:0], pair[23:16], clk_s);
                end
            end
        end

        wait (rst_n);
        while (cmd_queue.size() != 0 || s_tvalid)
            @(posedge clk);
        while (predicted_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: %0d ticks, %0d adds, %0d deletes, %0d ignored; table peaked at %0d of %0d.",
                 n_ticks, n_adds, n_dels, n_ignored, peak_count, TIMERS);
        $display("Summary: %0d timers fired, %0d adds refused as full, %0d deletes hit, %0d missed.",
                 n_fired, n_full, n_del_hit, n_del_miss);
        if (error_count == 0 && predicted_words.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog well past the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> periodic_timer_table_unit.f
+incdir+src
src/ptt_pkg.sv
src/ptt_ram.sv
src/ptt_engine.sv
src/periodic_timer_table_unit.sv
dv/testbench.sv
